[src/ps2mt_pkg.sv]
// Shared types, constants and the cursor clamp function for the PS/2 mouse packet tracker.
package ps2mt_pkg;

  localparam int unsigned LimitWidth = 11;
  localparam int unsigned PosWidth   = 10;
  localparam int unsigned InWidth    = 16;
  localparam int unsigned OutWidth   = 24;

  localparam logic [LimitWidth-1:0] XLimitReset = 11'd320;
  localparam logic [LimitWidth-1:0] YLimitReset = 11'd240;
  localparam logic [PosWidth-1:0]   PosMax      = 10'd1023;

  // Register indexes on the configuration port
  localparam logic RegXLimit = 1'b0;
  localparam logic RegYLimit = 1'b1;

  // Mouse protocol bytes and status bits
  localparam logic [7:0] ByteResetOk  = 8'hAA;
  localparam logic [7:0] ByteDeviceId = 8'h00;
  localparam int unsigned BitLeft     = 0;
  localparam int unsigned BitSync     = 3;
  localparam int unsigned BitSignX    = 4;
  localparam int unsigned BitSignY    = 5;

  localparam logic [1:0] CountLast = 2'd2;

  // Framer to cursor: what one byte did to the packet framing
  typedef struct packed {
    logic       send;
    logic       good;
    logic [7:0] status;
    logic [7:0] dx;
    logic [7:0] dy;
  } frame_evt_t;

  // Add a 9-bit signed delta and clamp to 0..min(limit-1, 1023); limit zero acts as one.
  function automatic logic [PosWidth-1:0] move_clamped(
    input logic [PosWidth-1:0]   pos,
    input logic                  neg,
    input logic [7:0]            mag,
    input logic [LimitWidth-1:0] limit
  );
    logic [LimitWidth-1:0] hi11;
    logic [PosWidth-1:0]   hi;
    logic signed [11:0]    v;
    begin
      hi11 = (limit == '0) ? '0 : limit - 11'd1;
      hi   = (hi11 > {1'b0, PosMax}) ? PosMax : hi11[PosWidth-1:0];
      v    = $signed({2'b00, pos}) + $signed({{4{neg}}, mag});
      if (v[11]) begin
        move_clamped = '0;
      end else if (v[10:0] > {1'b0, hi}) begin
        move_clamped = hi;
      end else begin
        move_clamped = v[PosWidth-1:0];
      end
    end
  endfunction

endpackage

[src/ps2mt_framer.sv]
// Byte window, modulo-3 framing counter, stream enable detection and sync check.
module ps2mt_framer
  import ps2mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       rx_valid,
  input  logic [7:0] rx_byte,
  output frame_evt_t evt
);

  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [1:0] byte_count;
  logic       streaming_on;

  logic [1:0] byte_count_next;
  logic       enable_hit;
  logic       wrap;
  logic       sync_bad;

  always_comb begin
    // window after shifting in: first <= second, second <= third, third <= byte
    enable_hit = !streaming_on && (byte_third == ByteResetOk) && (rx_byte == ByteDeviceId);
    wrap       = (byte_count == CountLast);
    sync_bad   = !byte_second[BitSync] || (byte_second[2:1] != 2'b00);

    if (enable_hit) begin
      byte_count_next = '0;
    end else if (wrap) begin
      byte_count_next = sync_bad ? CountLast : 2'd0;
    end else begin
      byte_count_next = byte_count + 2'd1;
    end

    evt.send   = rx_valid && enable_hit;
    evt.good   = rx_valid && !enable_hit && wrap && !sync_bad;
    evt.status = byte_second;
    evt.dx     = byte_third;
    evt.dy     = rx_byte;
  end

  // The oldest window byte is never read: the sync check looks at the byte that
  // is about to become it (byte_second)
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_second  <= '0;
      byte_third   <= '0;
      byte_count   <= '0;
      streaming_on <= 1'b0;
    end else if (step && rx_valid) begin
      byte_second  <= byte_third;
      byte_third   <= rx_byte;
      byte_count   <= byte_count_next;
      if (enable_hit) begin
        streaming_on <= 1'b1;
      end
    end
  end

endmodule

[src/ps2mt_cursor.sv]
// Cursor position, clamping and left button tracking.
module ps2mt_cursor
  import ps2mt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  frame_evt_t            evt,
  input  logic [LimitWidth-1:0] x_limit,
  input  logic [LimitWidth-1:0] y_limit,
  output logic [PosWidth-1:0]   pos_x,
  output logic [PosWidth-1:0]   pos_y,
  output logic                  left_button,
  output logic                  left_press
);

  logic [PosWidth-1:0] cursor_x;
  logic [PosWidth-1:0] cursor_y;
  logic                last_button;

  logic [PosWidth-1:0] cursor_x_next;
  logic [PosWidth-1:0] cursor_y_next;
  logic                clicked;

  always_comb begin
    clicked       = evt.status[BitLeft];
    cursor_x_next = move_clamped(cursor_x, evt.status[BitSignX], evt.dx, x_limit);
    cursor_y_next = move_clamped(cursor_y, evt.status[BitSignY], evt.dy, y_limit);
    if (evt.good) begin
      pos_x       = cursor_x_next;
      pos_y       = cursor_y_next;
      left_button = clicked;
      left_press  = clicked && !last_button;
    end else begin
      pos_x       = cursor_x;
      pos_y       = cursor_y;
      left_button = last_button;
      left_press  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      last_button <= 1'b0;
    end else if (step && evt.good) begin
      cursor_x    <= cursor_x_next;
      cursor_y    <= cursor_y_next;
      last_button <= clicked;
    end
  end

endmodule

[src/ps2_mouse_packet_tracker_top.sv]
// Top level of the PS/2 mouse packet tracker: stream ports, config registers, stage registers.
//
//  channel   | direction | word contents (low bit up)
//  ----------+-----------+----------------------------------------------------------
//  s_*       | in        | rx_valid[0], rx_byte[8:1], zero fill [15:9]
//  m_*       | out       | send_enable, packet_done, pos_x(10), pos_y(10),
//            |           | left_button, left_press
//  cfg_*     | in        | write enable, index 0 x_limit / 1 y_limit, 11-bit data
//
// One word per cycle sustained while m_tready stays high. A word is captured in the input
// register, passes combinationally through the framer and cursor logic and is loaded
// into the result register when it advances, that is when that register is free or being
// drained. rst is synchronous: it clears the stage valids, the framing state and
// the cursor, and loads the screen limits 320 and 240.
// A stall on m_tready holds the result register; the input register still takes one
// more word, and s_tready drops only when both stages are full.
module ps2_mouse_packet_tracker_top
  import ps2mt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // rx_valid [0], rx_byte [8:1], zeros [15:9]
  input  logic [InWidth-1:0]    s_tdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // send_enable [0], packet_done [1], pos_x [11:2], pos_y [21:12],
  // left_button [22], left_press [23]
  output logic [OutWidth-1:0]   m_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [LimitWidth-1:0] cfg_data
);

  logic [LimitWidth-1:0] x_limit;
  logic [LimitWidth-1:0] y_limit;

  logic       in_valid;
  logic       in_rx_valid;
  logic [7:0] in_rx_byte;

  logic       advance;
  frame_evt_t evt;

  logic [PosWidth-1:0] pos_x;
  logic [PosWidth-1:0] pos_y;
  logic                left_button;
  logic                left_press;

  // Advance the held word when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_limit <= XLimitReset;
      y_limit <= YLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        RegXLimit: x_limit <= cfg_data;
        RegYLimit: y_limit <= cfg_data;
        default:   ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_rx_valid <= s_tdata[0];
      in_rx_byte  <= s_tdata[8:1];
    end
  end

  ps2mt_framer u_framer (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_valid (in_rx_valid),
    .rx_byte  (in_rx_byte),
    .evt      (evt)
  );

  ps2mt_cursor u_cursor (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .evt         (evt),
    .x_limit     (x_limit),
    .y_limit     (y_limit),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .left_button (left_button),
    .left_press  (left_press)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {left_press, left_button, pos_y, pos_x, evt.good, evt.send};
    end
  end

endmodule

[tb/sv/ps2_mouse_packet_tracker_top_tb.sv]
// Self-checking testbench for the PS/2 mouse packet tracker top level.
`timescale 1ns / 100ps

module ps2_mouse_packet_tracker_top_tb
  import ps2mt_pkg::*;
();

  // Longest stretch without any handshake before the run is declared hung. The worst
  // correct case is the long receiver hold-off (HoldCycles) plus a config write.
  localparam int WatchLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int PhaseBytes = 170;

  // One port read as it travels in s_tdata, rx_valid in bit 0
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_valid;
  } port_read_t;

  // One report word as it travels in m_tdata, send_enable in bit 0
  typedef struct packed {
    logic       left_press;
    logic       left_button;
    logic [9:0] pos_y;
    logic [9:0] pos_x;
    logic       packet_done;
    logic       send_enable;
  } report_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic [InWidth-1:0]    s_tdata  = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OutWidth-1:0]   m_tdata;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic                  cfg_addr = RegXLimit;
  logic [LimitWidth-1:0] cfg_data = '0;

  ps2_mouse_packet_tracker_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Port reads waiting to be driven, and reports waiting to be seen
  port_read_t read_q[$];
  report_t    report_q[$];

  // Tracker state as the predictor sees it
  logic [7:0]            win_a = '0;   // oldest byte of the window
  logic [7:0]            win_b = '0;
  logic [7:0]            win_c = '0;   // newest byte
  logic [1:0]            frame_pos = '0;
  logic                  stream_on = 1'b0;
  logic [PosWidth-1:0]   cur_x = '0;
  logic [PosWidth-1:0]   cur_y = '0;
  logic                  btn_down = 1'b0;
  logic [LimitWidth-1:0] lim_x = XLimitReset;
  logic [LimitWidth-1:0] lim_y = YLimitReset;

  // Bookkeeping
  int n_queued = 0;
  int n_bytes_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_packets = 0;
  int n_presses = 0;
  int n_slips = 0;
  int n_enables = 0;

  // Pacing knobs, set per phase by the stimulus process
  logic tx_slow = 1'b1;
  logic rx_slow = 1'b1;
  int   hold_ask = 0;

  // Move one axis by a 9-bit signed delta; the top is limit-1, capped at 1023,
  // and a zero limit pins the axis at 0.
  function automatic logic [PosWidth-1:0] clamp_axis(input logic [PosWidth-1:0] pos,
                                                     input logic neg,
                                                     input logic [7:0] mag,
                                                     input logic [LimitWidth-1:0] limit);
    int top;
    int v;
    top = (limit == '0) ? 0 : int'(limit) - 1;
    if (top > int'(PosMax)) top = int'(PosMax);
    v = int'(pos) + (neg ? int'(mag) - 256 : int'(mag));
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v[PosWidth-1:0];
  endfunction

  // Advance the tracker by one port read and form the report it causes.
  task automatic track_read(input port_read_t rd, output report_t rep);
    logic clicked;
    rep = '0;
    if (rd.rx_valid) begin
      win_a = win_b;
      win_b = win_c;
      win_c = rd.rx_byte;
      if (!stream_on && win_b == ByteResetOk && win_c == ByteDeviceId) begin
        // Self-test pass plus device id: request streaming and restart framing
        rep.send_enable = 1'b1;
        frame_pos = '0;
        stream_on = 1'b1;
        n_enables++;
      end else begin
        frame_pos = (frame_pos == CountLast) ? 2'd0 : frame_pos + 2'd1;
        if (frame_pos == 2'd0) begin
          // Sync needs bit 3 set and the right and middle buttons (bits 1, 2) clear
          if (!win_a[BitSync] || win_a[2:1] != 2'b00) begin
            frame_pos = CountLast;
            n_slips++;
          end else begin
            clicked = win_a[BitLeft];
            cur_x = clamp_axis(cur_x, win_a[BitSignX], win_b, lim_x);
            cur_y = clamp_axis(cur_y, win_a[BitSignY], win_c, lim_y);
            rep.left_press  = clicked && !btn_down;
            rep.packet_done = 1'b1;
            btn_down = clicked;
            n_packets++;
            if (rep.left_press) n_presses++;
          end
        end
      end
    end
    rep.pos_x       = cur_x;
    rep.pos_y       = cur_y;
    rep.left_button = btn_down;
  endtask

  // ------------------------------------------------------------------
  // Sender: the posedge half records acceptance and predicts, the negedge
  // half drives the next word after a drawn gap.
  // ------------------------------------------------------------------
  port_read_t held_rd;
  report_t    fresh_rep;
  logic       s_took = 1'b0;
  int         tx_gap = 0;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      track_read(held_rd, fresh_rep);
      report_q.push_back(fresh_rep);
      n_taken++;
    end
    s_took <= !rst && s_tvalid && s_tready;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !s_took) begin
        // hold the word until the block takes it
      end else if (tx_gap > 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (read_q.size() > 0) begin
        held_rd = read_q.pop_front();
        s_tdata  <= {{(InWidth - 9){1'b0}}, held_rd};
        s_tvalid <= 1'b1;
        tx_gap = tx_slow ? $urandom_range(0, 14) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: capture at the rising edge, compare and steer m_tready at the
  // falling edge so the prediction of the same edge is already queued.
  // ------------------------------------------------------------------
  report_t m_word;
  report_t want;
  logic    m_took = 1'b0;
  int      rx_stall = 0;
  int      hold_left = 0;
  int      hold_seen = 0;

  task automatic check_field(input string tag, input logic [9:0] exp_val,
                             input logic [9:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, tag, exp_val, got_val);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    m_word <= m_tdata;
    m_took <= !rst && m_tvalid && m_tready;
  end

  always @(negedge clk) begin
    if (m_took) begin
      if (report_q.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, got %h", $time, m_word);
        n_fail++;
      end else begin
        want = report_q.pop_front();
        check_field("send_enable", 10'(want.send_enable), 10'(m_word.send_enable));
        check_field("packet_done", 10'(want.packet_done), 10'(m_word.packet_done));
        check_field("pos_x",       want.pos_x,            m_word.pos_x);
        check_field("pos_y",       want.pos_y,            m_word.pos_y);
        check_field("left_button", 10'(want.left_button), 10'(m_word.left_button));
        check_field("left_press",  10'(want.left_press),  10'(m_word.left_press));
      end
      n_checked++;
      rx_stall = rx_slow ? $urandom_range(0, 14) : 0;
    end
    // A new hold request starts a long back-pressure stretch
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HoldCycles;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: any cycle with a handshake on either side resets the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("%0t ns: no word moved for %0d cycles, %0d reports outstanding",
                 $time, quiet_cycles, n_taken - n_checked);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic queue_read(input logic valid, input logic [7:0] b);
    port_read_t rd;
    rd.rx_valid = valid;
    rd.rx_byte  = b;
    read_q.push_back(rd);
    n_queued++;
    if (valid) n_bytes_queued++;
  endtask

  // Occasionally slip an empty port read between bytes
  task automatic maybe_empty_read();
    if ($urandom_range(0, 9) == 0) queue_read(1'b0, 8'($urandom));
  endtask

  // Delta bytes lean on the ends of the range so the clamps get hit
  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_packet(input logic [7:0] status);
    queue_read(1'b1, status);
    maybe_empty_read();
    queue_read(1'b1, pick_delta());
    maybe_empty_read();
    queue_read(1'b1, pick_delta());
    maybe_empty_read();
  endtask

  function automatic logic [7:0] good_status();
    logic [7:0] st;
    st = 8'($urandom);
    st[BitSync] = 1'b1;
    st[2:1] = 2'b00;
    return st;
  endfunction

  // Mostly well-formed packets with random content; the rest is noise,
  // broken or cut-short packets, stray reset bytes and empty reads.
  task automatic queue_random(input int n_bytes);
    int stop_at;
    int sel;
    logic [7:0] st;
    stop_at = n_bytes_queued + n_bytes;
    while (n_bytes_queued < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 72) begin
        queue_packet(good_status());
      end else if (sel < 82) begin
        queue_read(1'b1, 8'($urandom));
      end else if (sel < 88) begin
        st = 8'($urandom);
        if ($urandom_range(0, 1)) st[BitSync] = 1'b0;
        else st[$urandom_range(1, 2)] = 1'b1;
        queue_packet(st);
      end else if (sel < 92) begin
        queue_read(1'b1, good_status());
        if ($urandom_range(0, 1)) queue_read(1'b1, pick_delta());
      end else if (sel < 95) begin
        queue_read(1'b1, ByteResetOk);
        queue_read(1'b1, ByteDeviceId);
      end else begin
        queue_read(1'b0, 8'($urandom));
      end
    end
  endtask

  // Write both limits back to back and mirror them in the predictor
  task automatic set_limits(input logic [LimitWidth-1:0] xl, input logic [LimitWidth-1:0] yl);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= RegXLimit;
    cfg_data <= xl;
    @(negedge clk);
    cfg_addr <= RegYLimit;
    cfg_data <= yl;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_x = xl;
    lim_y = yl;
  endtask

  // Wait until every queued read was taken and every report checked,
  // then let the two-stage pipe settle.
  task automatic wait_idle();
    @(posedge clk);
    while (n_taken != n_queued || n_checked != n_taken) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening with the reset limits 320 x 240
    queue_read(1'b0, 8'hFF);          // empty read with every data bit set
    queue_read(1'b1, 8'h00);
    queue_read(1'b1, 8'h08);          // first packet fails sync, framing slips
    queue_read(1'b1, 8'h05);
    queue_read(1'b1, 8'h03);          // slipped frame 08 05 03 is a good packet
    queue_read(1'b1, ByteResetOk);
    queue_read(1'b0, 8'h00);          // empty read between AA and 00 changes nothing
    queue_read(1'b1, ByteDeviceId);   // enable request, framing restarts
    queue_read(1'b1, 8'h09);          // left press, largest positive deltas
    queue_read(1'b1, 8'hFF);
    queue_read(1'b1, 8'hFF);
    queue_read(1'b1, 8'h39);          // left held, most negative deltas
    queue_read(1'b1, 8'h00);
    queue_read(1'b1, 8'h00);
    queue_read(1'b1, 8'h08);          // release
    queue_read(1'b1, 8'h10);
    queue_read(1'b1, 8'h10);
    queue_read(1'b1, ByteResetOk);    // AA 00 once streaming: no second enable
    queue_read(1'b1, ByteDeviceId);
    queue_read(1'b1, 8'hC9);          // overflow bits set, press again after resync
    queue_read(1'b1, 8'h01);
    queue_read(1'b1, 8'h01);
    queue_read(1'b1, 8'h0E);          // right and middle set: fails sync
    queue_read(1'b1, 8'h01);
    queue_read(1'b1, 8'h01);
    wait_idle();

    // Random phases, each under its own limit setting and pacing
    for (int p = 0; p < 7; p++) begin
      case (p)
        1: set_limits(11'd1, 11'd1);
        2: set_limits(11'd1024, 11'd1024);
        3: set_limits(11'd16, 11'd8);        // lowered below the current cursor
        4: set_limits(11'd0, 11'd2047);      // zero and beyond the screen range
        5: set_limits(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
        6: set_limits(11'd640, 11'd480);
        default: ;
      endcase
      tx_slow = ($urandom_range(0, 3) != 0);
      rx_slow = ($urandom_range(0, 3) != 0);
      if (p == 3) tx_slow = 1'b0;
      queue_random(PhaseBytes);
      // Back up the output while the sender keeps pushing
      if (p == 3) hold_ask++;
      wait_idle();
    end

    if (report_q.size() != 0) begin
      $display("%0t ns: %0d reports never arrived", $time, report_q.size());
      n_fail++;
    end

    $display("Ran %0d port reads (%0d bytes): %0d packets applied, %0d presses, %0d slips",
             n_taken, n_bytes_queued, n_packets, n_presses, n_slips);
    $display("Streaming enables %0d; limits swept from 0 to 2047; one long output stall",
             n_enables);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
